// ===== src/ovpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Oxygen valve PI control package
// Register indexes, reset values, stage word types and the constant dividers
// shared by the modules of the valve controller.
// ----------------------------------------------------------------------------
package ovpc_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 21;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_KP             = 3'd0,
      CSR_KI             = 3'd1,
      CSR_INTEGRAL_MAX   = 3'd2,
      CSR_INTEGRAL_MIN   = 3'd3,
      CSR_VALVE_OFF_CODE = 3'd4
   } csr_index_type;

   localparam logic [15:0]        KpReset           = 16'd0;
   localparam logic [15:0]        KiReset           = 16'd0;
   localparam logic [19:0]        IntegralMaxReset  = 20'd40950;
   localparam logic signed [20:0] IntegralMinReset  = 21'sd0;
   localparam logic [15:0]        ValveOffCodeReset = 16'd4095;
   localparam logic [16:0]        CmdLimitReset     = 17'(IntegralMaxReset / 10);

   // Reciprocals ceil(2^k / d), exact over the full input range of each use.
   localparam logic [29:0] Div125Mult   = 30'd549755814;
   localparam logic [24:0] Div10Mult    = 25'd26843546;
   localparam logic [20:0] Div10MaxMult = 21'd1677722;

   typedef struct packed {
      logic signed [23:0] prop;
      logic signed [23:0] delta;
      logic               enable;
   } gain_type;

   typedef struct packed {
      logic [23:0] magnitude;
      logic        negative;
      logic        enable;
   } sum_type;

   // Division by 1000 is a shift by 3 followed by a division by 125.
   function automatic logic [22:0] div_by_1000(input logic [31:0] value);
      logic [58:0] product;
      product = value[31:3] * Div125Mult;
      return product[58:36];
   endfunction

   function automatic logic [20:0] div_by_10(input logic [23:0] value);
      logic [48:0] product;
      product = value * Div10Mult;
      return product[48:28];
   endfunction

   function automatic logic [16:0] limit_of(input logic [19:0] value);
      logic [40:0] product;
      product = value * Div10MaxMult;
      return product[40:24];
   endfunction

endpackage

// ===== src/ovpc_csr.sv =====
// ----------------------------------------------------------------------------
// Oxygen valve PI control register file
// Holds the gain, clamp and off code registers and the derived command limit.
// ----------------------------------------------------------------------------
module ovpc_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ovpc_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [ovpc_pkg::CsrDataWidth-1:0]      csr_data,
   output logic [15:0]                            kp,
   output logic [15:0]                            ki,
   output logic [19:0]                            integral_max,
   output logic signed [20:0]                     integral_min,
   output logic [15:0]                            valve_off_code,
   output logic [16:0]                            cmd_limit
);

   logic [15:0]        kp_ff, kp_in;
   logic [15:0]        ki_ff, ki_in;
   logic [19:0]        integral_max_ff, integral_max_in;
   logic signed [20:0] integral_min_ff, integral_min_in;
   logic [15:0]        valve_off_code_ff, valve_off_code_in;
   logic [16:0]        cmd_limit_ff, cmd_limit_in;

   assign csr_ready = 1'b1;

   always_comb begin
      kp_in             = kp_ff;
      ki_in             = ki_ff;
      integral_max_in   = integral_max_ff;
      integral_min_in   = integral_min_ff;
      valve_off_code_in = valve_off_code_ff;
      cmd_limit_in      = ovpc_pkg::limit_of(integral_max_ff);
      if (csr_valid) begin
         unique case (ovpc_pkg::csr_index_type'(csr_index))
            ovpc_pkg::CSR_KP:             kp_in             = csr_data[15:0];
            ovpc_pkg::CSR_KI:             ki_in             = csr_data[15:0];
            ovpc_pkg::CSR_INTEGRAL_MAX:   integral_max_in   = csr_data[19:0];
            ovpc_pkg::CSR_INTEGRAL_MIN:   integral_min_in   = $signed(csr_data[20:0]);
            ovpc_pkg::CSR_VALVE_OFF_CODE: valve_off_code_in = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff             <= ovpc_pkg::KpReset;
         ki_ff             <= ovpc_pkg::KiReset;
         integral_max_ff   <= ovpc_pkg::IntegralMaxReset;
         integral_min_ff   <= ovpc_pkg::IntegralMinReset;
         valve_off_code_ff <= ovpc_pkg::ValveOffCodeReset;
         cmd_limit_ff      <= ovpc_pkg::CmdLimitReset;
      end else begin
         kp_ff             <= kp_in;
         ki_ff             <= ki_in;
         integral_max_ff   <= integral_max_in;
         integral_min_ff   <= integral_min_in;
         valve_off_code_ff <= valve_off_code_in;
         cmd_limit_ff      <= cmd_limit_in;
      end
   end

   assign kp             = kp_ff;
   assign ki             = ki_ff;
   assign integral_max   = integral_max_ff;
   assign integral_min   = integral_min_ff;
   assign valve_off_code = valve_off_code_ff;
   assign cmd_limit      = cmd_limit_ff;

endmodule

// ===== src/ovpc_gain.sv =====
// ----------------------------------------------------------------------------
// Oxygen valve PI control gain stages
// Registers the request, forms the error and both gain products, and divides
// them by 1000 with truncation toward zero.
// ----------------------------------------------------------------------------
module ovpc_gain (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [15:0]       req_setpoint,
   input  logic signed [15:0]       req_measured_flow,
   input  logic [6:0]               req_oxygen_adjust,
   input  logic                     req_full_oxygen_active,
   input  logic                     req_maintenance_active,
   input  logic [15:0]              kp,
   input  logic [15:0]              ki,
   output logic                     out_valid,
   input  logic                     out_ready,
   output ovpc_pkg::gain_type       out_data
);

   logic               s0_valid_ff, s0_valid_in;
   logic signed [15:0] setpoint_ff;
   logic signed [15:0] flow_ff;
   logic               s0_enable_ff;

   logic               s1_valid_ff, s1_valid_in;
   logic [31:0]        prop_mag_ff, prop_mag_in;
   logic [31:0]        delta_mag_ff, delta_mag_in;
   logic               negative_ff, negative_in;
   logic               s1_enable_ff;

   logic               s2_valid_ff, s2_valid_in;
   ovpc_pkg::gain_type s2_data_ff, s2_data_in;

   logic               s0_load;
   logic               s1_load;
   logic               s2_load;
   logic signed [16:0] error;
   logic [16:0]        error_abs;
   logic [23:0]        prop_q;
   logic [23:0]        delta_q;

   assign s2_load   = !s2_valid_ff || out_ready;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign s0_load   = !s0_valid_ff || s1_load;
   assign req_ready = s0_load;

   always_comb begin
      s0_valid_in = s0_load ? req_valid : s0_valid_ff;
      s1_valid_in = s1_load ? s0_valid_ff : s1_valid_ff;
      s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;
   end

   always_comb begin
      error        = 17'(setpoint_ff) - 17'(flow_ff);
      negative_in  = error[16];
      error_abs    = negative_in ? 17'(-error) : 17'(error);
      prop_mag_in  = kp * error_abs[15:0];
      delta_mag_in = ki * error_abs[15:0];
   end

   always_comb begin
      prop_q             = {1'b0, ovpc_pkg::div_by_1000(prop_mag_ff)};
      delta_q            = {1'b0, ovpc_pkg::div_by_1000(delta_mag_ff)};
      s2_data_in.prop    = negative_ff ? $signed(-prop_q) : $signed(prop_q);
      s2_data_in.delta   = negative_ff ? $signed(-delta_q) : $signed(delta_q);
      s2_data_in.enable  = s1_enable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_load) begin
         setpoint_ff  <= req_setpoint;
         flow_ff      <= req_measured_flow;
         s0_enable_ff <= (req_oxygen_adjust != 7'd0) || req_full_oxygen_active
                         || req_maintenance_active;
      end
      if (s1_load) begin
         prop_mag_ff  <= prop_mag_in;
         delta_mag_ff <= delta_mag_in;
         negative_ff  <= negative_in;
         s1_enable_ff <= s0_enable_ff;
      end
      if (s2_load) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

// ===== src/ovpc_integ.sv =====
// ----------------------------------------------------------------------------
// Oxygen valve PI control integrator
// Accumulates the integral term with its clamps and forms the magnitude and
// sign of proportional plus integral.
// ----------------------------------------------------------------------------
module ovpc_integ (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ovpc_pkg::gain_type    in_data,
   input  logic [19:0]           integral_max,
   input  logic signed [20:0]    integral_min,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ovpc_pkg::sum_type     out_data
);

   logic               s3_valid_ff, s3_valid_in;
   logic signed [20:0] integral_ff, integral_in;
   logic signed [23:0] prop_ff;
   logic               s3_enable_ff;

   logic               s4_valid_ff, s4_valid_in;
   ovpc_pkg::sum_type  s4_data_ff, s4_data_in;

   logic               s3_load;
   logic               s4_load;
   logic               s3_take;
   logic signed [24:0] integ_sum;
   logic signed [24:0] integ_clamped;
   logic signed [24:0] max_ext;
   logic signed [24:0] min_ext;
   logic signed [24:0] total;
   logic [24:0]        total_abs;

   assign s4_load  = !s4_valid_ff || out_ready;
   assign s3_load  = !s3_valid_ff || s4_load;
   assign s3_take  = s3_load && in_valid;
   assign in_ready = s3_load;

   always_comb begin
      s3_valid_in = s3_load ? in_valid : s3_valid_ff;
      s4_valid_in = s4_load ? s3_valid_ff : s4_valid_ff;
   end

   // The lower clamp is applied last, so it wins when the clamps conflict.
   always_comb begin
      max_ext       = $signed({5'b0, integral_max});
      min_ext       = 25'(integral_min);
      integ_sum     = 25'(integral_ff) + 25'(in_data.delta);
      integ_clamped = integ_sum;
      if (integ_clamped > max_ext) begin
         integ_clamped = max_ext;
      end
      if (integ_clamped < min_ext) begin
         integ_clamped = min_ext;
      end
      integral_in = s3_take ? integ_clamped[20:0] : integral_ff;
   end

   always_comb begin
      total                = 25'(prop_ff) + 25'(integral_ff);
      total_abs            = total[24] ? 25'(-total) : 25'(total);
      s4_data_in.magnitude = total_abs[23:0];
      s4_data_in.negative  = total[24];
      s4_data_in.enable    = s3_enable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         integral_ff <= '0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
         integral_ff <= integral_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_take) begin
         prop_ff      <= in_data.prop;
         s3_enable_ff <= in_data.enable;
      end
      if (s4_load) begin
         s4_data_ff <= s4_data_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_data_ff;

endmodule

// ===== src/ovpc_cmd.sv =====
// ----------------------------------------------------------------------------
// Oxygen valve PI control command stages
// Divides the controller sum by ten, clamps the command and forms the valve
// drive in the result register.
// ----------------------------------------------------------------------------
module ovpc_cmd (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ovpc_pkg::sum_type   in_data,
   input  logic [16:0]         cmd_limit,
   input  logic [15:0]         valve_off_code,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_valve_drive,
   output logic [15:0]         rsp_valve_command
);

   logic        s5_valid_ff, s5_valid_in;
   logic [20:0] quotient_ff;
   logic        s5_negative_ff;
   logic        s5_enable_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] drive_ff, drive_in;
   logic [15:0] command_ff, command_in;

   logic        s5_load;
   logic        rsp_load;
   logic [16:0] command_full;

   assign rsp_load = !rsp_valid_ff || rsp_ready;
   assign s5_load  = !s5_valid_ff || rsp_load;
   assign in_ready = s5_load;

   always_comb begin
      s5_valid_in  = s5_load ? in_valid : s5_valid_ff;
      rsp_valid_in = rsp_load ? s5_valid_ff : rsp_valid_ff;
   end

   // A negative sum gives a zero command rather than a wrapped one.
   always_comb begin
      if (s5_negative_ff) begin
         command_full = '0;
      end else if (quotient_ff > 21'(cmd_limit)) begin
         command_full = cmd_limit;
      end else begin
         command_full = quotient_ff[16:0];
      end
      command_in = command_full[15:0];
      drive_in   = s5_enable_ff ? 16'(valve_off_code - command_in) : valve_off_code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff  <= s5_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_load) begin
         quotient_ff    <= ovpc_pkg::div_by_10(in_data.magnitude);
         s5_negative_ff <= in_data.negative;
         s5_enable_ff   <= in_data.enable;
      end
      if (rsp_load) begin
         drive_ff   <= drive_in;
         command_ff <= command_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_valve_drive   = drive_ff;
   assign rsp_valve_command = command_ff;

endmodule

// ===== src/oxygen_valve_pi_control.sv =====
// ----------------------------------------------------------------------------
// Oxygen valve PI control
// Each request word is one control tick: setpoint, measured flow, the adjust
// setting and the two override flags. Each tick returns one response word
// with the valve drive code and the clamped PI command.
// The request and response channels use valid and ready; a word moves when
// both are high. Gains, integral clamps and the valve off code are written
// through the register channel, which is always ready and is meant to be
// used only while no tick is in flight.
// A response word passes through a 7-register pipeline: input, gain multiply,
// divide by 1000, integral update, sum, divide by 10 and the response
// register. One tick is taken per cycle while request ready is high; the
// integral is carried from tick to tick in the single integrator register,
// so back-to-back ticks need not wait for one another.
// When the receiver stalls, words collect in the empty pipeline stages and
// request ready drops only once all stages hold a word.
// Reset empties the pipeline, clears the integral and loads the register
// defaults; it takes effect at the next clock edge.
// ----------------------------------------------------------------------------
module oxygen_valve_pi_control (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [15:0]                  req_setpoint,
   input  logic signed [15:0]                  req_measured_flow,
   input  logic [6:0]                          req_oxygen_adjust,
   input  logic                                req_full_oxygen_active,
   input  logic                                req_maintenance_active,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [15:0]                         rsp_valve_drive,
   output logic [15:0]                         rsp_valve_command,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ovpc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [ovpc_pkg::CsrDataWidth-1:0]   csr_data
);

   logic [15:0]        kp;
   logic [15:0]        ki;
   logic [19:0]        integral_max;
   logic signed [20:0] integral_min;
   logic [15:0]        valve_off_code;
   logic [16:0]        cmd_limit;

   logic               gain_valid;
   logic               gain_ready;
   ovpc_pkg::gain_type gain_data;
   logic               sum_valid;
   logic               sum_ready;
   ovpc_pkg::sum_type  sum_data;

   ovpc_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .kp             (kp),
      .ki             (ki),
      .integral_max   (integral_max),
      .integral_min   (integral_min),
      .valve_off_code (valve_off_code),
      .cmd_limit      (cmd_limit)
   );

   ovpc_gain u_gain (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_setpoint           (req_setpoint),
      .req_measured_flow      (req_measured_flow),
      .req_oxygen_adjust      (req_oxygen_adjust),
      .req_full_oxygen_active (req_full_oxygen_active),
      .req_maintenance_active (req_maintenance_active),
      .kp                     (kp),
      .ki                     (ki),
      .out_valid              (gain_valid),
      .out_ready              (gain_ready),
      .out_data               (gain_data)
   );

   ovpc_integ u_integ (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (gain_valid),
      .in_ready     (gain_ready),
      .in_data      (gain_data),
      .integral_max (integral_max),
      .integral_min (integral_min),
      .out_valid    (sum_valid),
      .out_ready    (sum_ready),
      .out_data     (sum_data)
   );

   ovpc_cmd u_cmd (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (sum_valid),
      .in_ready          (sum_ready),
      .in_data           (sum_data),
      .cmd_limit         (cmd_limit),
      .valve_off_code    (valve_off_code),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_valve_drive   (rsp_valve_drive),
      .rsp_valve_command (rsp_valve_command)
   );

   // The command never exceeds the configured limit.
   a_command_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_valve_command} <= cmd_limit))
      else $error("valve command above limit");

   // The drive is either the off code or the off code less the command.
   a_drive_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_valve_drive == valve_off_code)
                     || (rsp_valve_drive == 16'(valve_off_code - rsp_valve_command))))
      else $error("valve drive inconsistent with command");

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oxygen valve PI control testbench
// Sends control ticks to the valve controller. A short table of edge cases
// comes first, then random phases, each with fresh gains, clamps and off
// code. Both channels idle at random. Every response word is compared
// with its table word or a behavioral PI model tracking its own integral.
// ----------------------------------------------------------------------------
module testbench;

   localparam int GainScale     = 1000;
   localparam int CommandScale  = 10;
   localparam int MaxIdle       = 17;
   localparam int SettleCycles  = 10;
   localparam int WatchdogLimit = 2000;
   localparam int RandomTicks   = 1350;
   localparam int DirectedCount = 21;
   localparam int SpareIndexCount = 3;
   localparam logic [ovpc_pkg::CsrIndexWidth-1:0] CsrIndexFirstSpare = 3'd5;
   localparam logic [15:0] OffReset = ovpc_pkg::ValveOffCodeReset;

   typedef struct packed {
      logic [15:0]        kp;
      logic [15:0]        ki;
      logic [19:0]        integral_max;
      logic signed [20:0] integral_min;
      logic [15:0]        off_code;
   } loop_gains_type;

   typedef struct packed {
      logic [1:0]         setting;
      logic signed [15:0] setpoint;
      logic signed [15:0] flow;
      logic [6:0]         adjust;
      logic               full_oxygen;
      logic               maintenance;
      logic               known;
      logic [15:0]        drive;
      logic [15:0]        command;
   } tick_row_type;

   typedef struct packed {
      logic [15:0] drive;
      logic [15:0] command;
   } valve_word_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic signed [15:0]                 req_setpoint = '0;
   logic signed [15:0]                 req_measured_flow = '0;
   logic [6:0]                         req_oxygen_adjust = '0;
   logic                               req_full_oxygen_active = 1'b0;
   logic                               req_maintenance_active = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [15:0]                        rsp_valve_drive;
   logic [15:0]                        rsp_valve_command;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [ovpc_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [ovpc_pkg::CsrDataWidth-1:0]  csr_data = '0;

   logic [15:0]        kp_now = ovpc_pkg::KpReset;
   logic [15:0]        ki_now = ovpc_pkg::KiReset;
   logic [19:0]        max_now = ovpc_pkg::IntegralMaxReset;
   logic signed [20:0] min_now = ovpc_pkg::IntegralMinReset;
   logic [15:0]        off_now = ovpc_pkg::ValveOffCodeReset;
   longint             integral_track = 0;

   valve_word_type pending_words[$];
   valve_word_type due_word;
   int             mismatch_count = 0;
   int             response_count = 0;
   int             quiet_cycles = 0;
   int             rsp_hold = 0;
   logic           calm = 1'b0;

   tick_row_type       row;
   int                 active_setting;
   int                 random_sent;
   int                 phase_len;
   logic signed [15:0] tick_setpoint;
   logic signed [15:0] tick_flow;

   loop_gains_type gain_settings [4] = '{
      '{ovpc_pkg::KpReset, ovpc_pkg::KiReset, ovpc_pkg::IntegralMaxReset,
        ovpc_pkg::IntegralMinReset, OffReset},
      '{16'd2000, 16'd500, 20'd655350, -21'sd655350, 16'd65535},
      '{16'd0, 16'd1000, 20'd100, 21'sd500, 16'd3},
      '{16'd65535, 16'd65535, 20'hFFFFF, 21'h100000, 16'd0}
   };

   // Rows under the reset setting carry their expected word; the rest are
   // predicted.
   tick_row_type directed_ticks [DirectedCount] = '{
      '{2'd0, 16'sh0000, 16'sh0000, 7'd0,   1'b0, 1'b0, 1'b1, OffReset, 16'd0},
      '{2'd0, 16'sh7FFF, 16'sh8000, 7'd100, 1'b0, 1'b0, 1'b1, OffReset, 16'd0},
      '{2'd0, 16'sh8000, 16'sh7FFF, 7'd127, 1'b1, 1'b1, 1'b1, OffReset, 16'd0},
      '{2'd0, 16'sh7FFF, 16'sh7FFF, 7'd0,   1'b1, 1'b0, 1'b1, OffReset, 16'd0},
      '{2'd0, 16'shFFFF, 16'sh0000, 7'd0,   1'b0, 1'b1, 1'b1, OffReset, 16'd0},
      '{2'd0, 16'sh5555, 16'shAAAA, 7'h55,  1'b0, 1'b0, 1'b1, OffReset, 16'd0},
      '{2'd0, 16'shAAAA, 16'sh5555, 7'h2A,  1'b1, 1'b0, 1'b1, OffReset, 16'd0},
      '{2'd1, 16'sd1000, 16'sh0000, 7'd50,  1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd1, 16'sd1000, 16'sh0000, 7'd50,  1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd1, 16'sh8000, 16'sh7FFF, 7'd1,   1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd1, 16'sh7FFF, 16'sh8000, 7'd0,   1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd1, 16'sh7FFF, 16'sh8000, 7'd0,   1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd1, 16'sh7FFF, 16'sh8000, 7'd0,   1'b0, 1'b1, 1'b0, 16'd0, 16'd0},
      '{2'd1, 16'sh0000, 16'sh0000, 7'd127, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd2, 16'sd10,   16'sh0000, 7'd10,  1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd2, -16'sd5000, 16'sd5000, 7'd10, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd2, 16'sd100,  16'sh0000, 7'd0,   1'b1, 1'b1, 1'b0, 16'd0, 16'd0},
      '{2'd3, 16'sh7FFF, 16'sh8000, 7'd5,   1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd3, 16'sh8000, 16'sh7FFF, 7'd5,   1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd3, 16'sh7FFF, 16'sh8000, 7'd5,   1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd3, 16'sd1,    16'sh0000, 7'd100, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0}
   };

   oxygen_valve_pi_control dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_idle();
      return calm ? 0 : $urandom_range(0, MaxIdle);
   endfunction

   function automatic valve_word_type predict_valve_word(input logic signed [15:0] setpoint,
         input logic signed [15:0] flow, input logic [6:0] adjust,
         input logic full_oxygen, input logic maintenance);
      longint         flow_error;
      longint         proportional;
      longint         integral;
      longint         command;
      longint         limit;
      valve_word_type word;
      flow_error = longint'(setpoint) - longint'(flow);
      proportional = longint'(kp_now) * flow_error / GainScale;
      integral = integral_track + longint'(ki_now) * flow_error / GainScale;
      if (integral > longint'(max_now)) integral = longint'(max_now);
      if (integral < longint'(min_now)) integral = longint'(min_now);
      integral_track = integral;
      command = (proportional + integral) / CommandScale;
      limit = longint'(max_now) / CommandScale;
      if (command > limit) command = limit;
      if (command < 0) command = 0;
      word.command = command[15:0];
      if (adjust != 7'd0 || full_oxygen || maintenance) word.drive = off_now - word.command;
      else word.drive = off_now;
      return word;
   endfunction

   function automatic logic [15:0] random_gain();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return 16'($urandom_range(0, 3000));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic loop_gains_type random_gains();
      loop_gains_type g;
      g.kp = random_gain();
      g.ki = random_gain();
      case ($urandom_range(0, 4))
         0: g.integral_max = '0;
         1: g.integral_max = 20'd655350;
         2: g.integral_max = '1;
         3: g.integral_max = 20'($urandom_range(0, 60000));
         default: g.integral_max = 20'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0: g.integral_min = '0;
         1: g.integral_min = -21'sd655350;
         2: g.integral_min = 21'h100000;
         3: g.integral_min = -21'($urandom_range(0, 60000));
         default: g.integral_min = 21'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0: g.off_code = '0;
         1: g.off_code = '1;
         2: g.off_code = OffReset;
         default: g.off_code = 16'($urandom);
      endcase
      return g;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
         input logic [15:0] want);
      $display("mismatch at response word %0d: %s got %0d, expected %0d",
               response_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic write_register(input logic [ovpc_pkg::CsrIndexWidth-1:0] index,
         input logic [ovpc_pkg::CsrDataWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         ovpc_pkg::CSR_KP: kp_now = data[15:0];
         ovpc_pkg::CSR_KI: ki_now = data[15:0];
         ovpc_pkg::CSR_INTEGRAL_MAX: max_now = data[19:0];
         ovpc_pkg::CSR_INTEGRAL_MIN: min_now = data;
         ovpc_pkg::CSR_VALVE_OFF_CODE: off_now = data[15:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_gains(input loop_gains_type g);
      write_register(ovpc_pkg::CSR_KP, {5'($urandom), g.kp});
      write_register(ovpc_pkg::CSR_KI, {5'($urandom), g.ki});
      write_register(ovpc_pkg::CSR_INTEGRAL_MAX, {1'($urandom), g.integral_max});
      write_register(ovpc_pkg::CSR_INTEGRAL_MIN, g.integral_min);
      write_register(ovpc_pkg::CSR_VALVE_OFF_CODE, {5'($urandom), g.off_code});
      write_register(CsrIndexFirstSpare + 3'($urandom_range(0, SpareIndexCount - 1)),
                     21'($urandom));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic send_tick(input logic signed [15:0] setpoint,
         input logic signed [15:0] flow, input logic [6:0] adjust,
         input logic full_oxygen, input logic maintenance, input logic known,
         input logic [15:0] drive, input logic [15:0] command);
      int             gap;
      valve_word_type word;
      gap = draw_idle();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_setpoint <= setpoint;
      req_measured_flow <= flow;
      req_oxygen_adjust <= adjust;
      req_full_oxygen_active <= full_oxygen;
      req_maintenance_active <= maintenance;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      word = predict_valve_word(setpoint, flow, adjust, full_oxygen, maintenance);
      if (known) begin
         word.drive = drive;
         word.command = command;
      end
      pending_words.push_back(word);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            report_mismatch("word with no tick pending, command", rsp_valve_command, 16'd0);
         end else begin
            due_word = pending_words.pop_front();
            if (rsp_valve_drive !== due_word.drive)
               report_mismatch("valve_drive", rsp_valve_drive, due_word.drive);
            if (rsp_valve_command !== due_word.command)
               report_mismatch("valve_command", rsp_valve_command, due_word.command);
         end
         response_count++;
         rsp_hold = draw_idle();
         rsp_ready <= (rsp_hold == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_ready <= (rsp_hold == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("timeout: no word moved for %0d cycles", WatchdogLimit);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      active_setting = 0;
      for (int i = 0; i < DirectedCount; i++) begin
         row = directed_ticks[i];
         if (row.setting != active_setting) begin
            settle();
            load_gains(gain_settings[row.setting]);
            active_setting = row.setting;
         end
         send_tick(row.setpoint, row.flow, row.adjust, row.full_oxygen, row.maintenance,
                   row.known, row.drive, row.command);
      end
      random_sent = 0;
      while (random_sent < RandomTicks) begin
         settle();
         load_gains(random_gains());
         calm = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(20, 80);
         for (int n = 0; n < phase_len; n++) begin
            tick_setpoint = 16'($urandom);
            if ($urandom_range(0, 1) != 0)
               tick_flow = tick_setpoint - 16'sd200 + 16'($urandom_range(0, 400));
            else
               tick_flow = 16'($urandom);
            send_tick(tick_setpoint, tick_flow,
                      ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(0, 127)),
                      ($urandom_range(0, 3) == 0), ($urandom_range(0, 3) == 0),
                      1'b0, 16'd0, 16'd0);
         end
         random_sent += phase_len;
      end
      settle();
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
